// File: sv/gf2rr_pkg.sv
// ---------------------------------------------------------------------------
// gf2rr_pkg
// Types and constants shared by the GF(2) incremental row reduction block.
// ---------------------------------------------------------------------------
package gf2rr_pkg;

    localparam int unsigned ROW_W   = 64;
    localparam int unsigned ASG_W   = 63;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned RANK_W  = 7;
    localparam int unsigned NUM_ROW = 64;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REDUCE = 2'd1,
        REQ_SOLVE  = 2'd2,
        REQ_EVAL   = 2'd3
    } t_req_kind;

    typedef struct packed {
        t_req_kind          req_type;
        logic [ROW_W-1:0]   row_bits;
        logic [ASG_W-1:0]   assignment;
    } t_req;

    typedef struct packed {
        logic [ROW_W-1:0]   result_row;
        logic               independent;
        logic [RANK_W-1:0]  rank;
        logic               consistent;
        logic [ASG_W-1:0]   solution;
        logic               satisfied;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SLAST,
        ST_PIV,
        ST_BACK,
        ST_BLAST,
        ST_WRITE,
        ST_DONE
    } t_state;

endpackage

// File: sv/gf2_incremental_row_reduction.sv
// ---------------------------------------------------------------------------
// gf2_incremental_row_reduction
// Keeps a fully reduced echelon basis of affine XOR equations over GF(2).
// Insert, reduce, solve and evaluate requests share one row RAM and one
// XOR/parity unit that sweeps the 64 pivot slots under a small sequencer.
//
//   channel | valid      | stall        | payload
//   --------+------------+--------------+-----------
//   request | i_in_valid | o_in_stall   | i_in_data
//   result  | o_out_valid| i_out_stall  | o_out_data
//
// Reduce, solve, evaluate: one 64-slot sweep, then the result is registered.
// Insert: a dependent row ends after the reduce sweep; an independent row adds
// pivot search, back-reduction sweep with read-modify-write, store of the new row.
// One request at a time: o_in_stall is high from transfer until the result is
// registered; a stalled result holds while the next request may transfer, and the
// next result waits in the sequencer until the output register is free.
// Reset clears pivot valid bits and rank; the row RAM needs no clearing.
// ---------------------------------------------------------------------------
module gf2_incremental_row_reduction #(
    parameter int unsigned NUM_VARS = 63
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gf2rr_pkg::t_req   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output gf2rr_pkg::t_rsp   o_out_data
);
    import gf2rr_pkg::*;

    localparam logic [ROW_W-1:0] RowMask = {ROW_W{1'b1}} >> (ROW_W - 1 - NUM_VARS);

    t_state             r_state, n_state;
    t_req_kind          r_req;
    logic [ROW_W-1:0]   r_row;
    logic [ASG_W-1:0]   r_asg;
    logic               r_sat;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_pd;
    logic               r_dv;
    logic [IDX_W-1:0]   r_np;
    logic [NUM_ROW-1:0] r_valid;
    logic [RANK_W-1:0]  r_count;
    logic               r_ovld;
    t_rsp               r_odata;

    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [ROW_W-1:0]   w_wdata;
    logic [ROW_W-1:0]   w_rdata;
    logic               w_hit;
    logic               w_par;
    logic               w_accept;
    logic               w_load;
    logic               w_last;
    logic               w_rowop;
    t_rsp               w_rsp;

    function automatic logic [IDX_W-1:0] f_lowest(input logic [ROW_W-1:0] row);
        logic [ROW_W-1:0] v;
        logic [2:0]       byte_i;
        logic [2:0]       bit_i;
        logic [7:0]       sel;
        v      = {row[ROW_W-1:1], 1'b0};
        byte_i = 3'd0;
        bit_i  = 3'd0;
        for (int b = 7; b >= 0; b--) begin
            if (v[b*8 +: 8] != 8'd0) begin
                byte_i = 3'(b);
            end
        end
        sel = v[{byte_i, 3'b000} +: 8];
        for (int k = 7; k >= 0; k--) begin
            if (sel[k]) begin
                bit_i = 3'(k);
            end
        end
        return {byte_i, bit_i};
    endfunction

    gf2rr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_ROW)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // shared unit: slot hit and row parity under the current assignment
    assign w_hit  = r_dv && r_valid[r_pd];
    assign w_par  = (^(w_rdata[ROW_W-1:1] & r_asg)) ^ w_rdata[0];
    assign w_last = (r_idx == IDX_W'(NUM_ROW - 1));
    assign w_rowop = (r_req == REQ_INSERT) || (r_req == REQ_REDUCE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_SCAN;
            ST_SCAN:  if (w_last) n_state = ST_SLAST;
            ST_SLAST: n_state = (r_req == REQ_INSERT) ? ST_PIV : ST_DONE;
            ST_PIV:   begin
                if (r_row != '0 && r_count < RANK_W'(NUM_ROW)) begin
                    n_state = ST_BACK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_BACK:  if (w_last) n_state = ST_BLAST;
            ST_BLAST: n_state = ST_WRITE;
            ST_WRITE: n_state = ST_DONE;
            ST_DONE:  if (!r_ovld || !i_out_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        w_accept   = (r_state == ST_IDLE) && i_in_valid;
        w_load     = (r_state == ST_DONE) && (!r_ovld || !i_out_stall);
        w_we       = 1'b0;
        w_waddr    = r_pd;
        w_wdata    = w_rdata ^ r_row;
        case (r_state)
            ST_BACK, ST_BLAST: w_we = w_hit && w_rdata[r_np];
            ST_WRITE: begin
                w_we    = 1'b1;
                w_waddr = r_np;
                w_wdata = r_row;
            end
            default: w_we = 1'b0;
        endcase
    end

    always_comb begin
        w_rsp.result_row  = w_rowop ? r_row : '0;
        w_rsp.independent = w_rowop && (r_row != '0);
        w_rsp.rank        = r_count;
        w_rsp.consistent  = !r_valid[0];
        w_rsp.solution    = r_asg;
        w_rsp.satisfied   = (r_req == REQ_EVAL) && r_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_dv    <= 1'b0;
            r_valid <= '0;
            r_count <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pd    <= r_idx;
            r_dv    <= (r_state == ST_SCAN) || (r_state == ST_BACK);
            if (r_state == ST_SCAN || r_state == ST_BACK) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (w_accept) begin
                r_req <= i_in_data.req_type;
                r_row <= i_in_data.row_bits & RowMask;
                r_asg <= i_in_data.assignment;
                r_sat <= 1'b1;
                r_idx <= '0;
            end
            if ((r_state == ST_SCAN || r_state == ST_SLAST) && w_hit) begin
                case (r_req)
                    REQ_INSERT, REQ_REDUCE: if (r_row[r_pd]) r_row <= r_row ^ w_rdata;
                    REQ_SOLVE: begin
                        if (r_pd != '0 && w_par) begin
                            r_asg[r_pd - IDX_W'(1)] <= !r_asg[r_pd - IDX_W'(1)];
                        end
                    end
                    REQ_EVAL: if (w_par) r_sat <= 1'b0;
                    default: r_sat <= r_sat;
                endcase
            end
            if (r_state == ST_PIV) begin
                r_np <= f_lowest(r_row);
            end
            if (r_state == ST_WRITE) begin
                r_valid[r_np] <= 1'b1;
                r_count       <= r_count + RANK_W'(1);
            end
            if (w_load) begin
                r_ovld  <= 1'b1;
                r_odata <= w_rsp;
            end else if (!i_out_stall) begin
                r_ovld  <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_data  = r_odata;

endmodule

// File: sv/gf2rr_ram.sv
// ---------------------------------------------------------------------------
// gf2rr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module gf2rr_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for gf2_incremental_row_reduction. Requests are checked
// against an in-bench GF(2) echelon basis tracker: directed corner cases on an
// empty and a partly filled basis, random traffic in four traffic phases,
// then a top-up to a full basis that includes the constant row.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gf2rr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 200;

    typedef enum int {
        TRAFFIC_STEADY,
        TRAFFIC_SRC_GAPS,
        TRAFFIC_SINK_STALLS,
        TRAFFIC_BOTH
    } t_traffic;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_req in_data   = '0;
    logic out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_rsp o_out_data;

    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int error_count    = 0;
    int idle_cycles    = 0;

    // basis tracker
    logic [ROW_W-1:0]  basis_rows [NUM_ROW];
    logic [IDX_W-1:0]  pivot_slot [NUM_ROW];
    logic [NUM_ROW-1:0] pivot_mask = '0;
    logic [RANK_W-1:0] basis_rank = '0;

    t_rsp             expected_rsp_q [$];
    logic [ROW_W-1:0] inserted_rows [$];

    wire in_xfer  = in_valid && !o_in_stall;
    wire out_xfer = o_out_valid && !out_stall;

    gf2_incremental_row_reduction uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [ROW_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic row_parity(logic [ROW_W-1:0] r, logic [ASG_W-1:0] a);
        return r[0] ^ (^(r[ROW_W-1:1] & a));
    endfunction

    function automatic logic [ROW_W-1:0] reduce_by_basis(logic [ROW_W-1:0] r);
        for (int p = 0; p < NUM_ROW; p++) begin
            if (pivot_mask[p] && r[p]) begin
                r ^= basis_rows[pivot_slot[p]];
            end
        end
        return r;
    endfunction

    function automatic logic [ASG_W-1:0] fix_assignment(logic [ASG_W-1:0] a);
        if (basis_rank != 0) begin
            for (int p = 1; p < NUM_ROW; p++) begin
                if (pivot_mask[p] && row_parity(basis_rows[pivot_slot[p]], a)) begin
                    a[p-1] = ~a[p-1];
                end
            end
        end
        return a;
    endfunction

    function automatic t_rsp predict_response(t_req q);
        t_rsp             s;
        logic [ROW_W-1:0] red;
        logic [IDX_W-1:0] slot;
        int               np;
        s = '0;
        s.solution = q.assignment;
        case (q.req_type)
            REQ_INSERT, REQ_REDUCE: begin
                red = reduce_by_basis(q.row_bits);
                s.result_row  = red;
                s.independent = (red != '0);
                if (q.req_type == REQ_INSERT && red != '0 && basis_rank < NUM_ROW) begin
                    np = 0;
                    for (int k = ROW_W - 1; k >= 1; k--) begin
                        if (red[k]) np = k;
                    end
                    slot = basis_rank[IDX_W-1:0];
                    basis_rows[slot] = red;
                    for (int p = 0; p < NUM_ROW; p++) begin
                        if (pivot_mask[p] && basis_rows[pivot_slot[p]][np]) begin
                            basis_rows[pivot_slot[p]] ^= red;
                        end
                    end
                    pivot_mask[np] = 1'b1;
                    pivot_slot[np] = slot;
                    basis_rank++;
                end
            end
            REQ_SOLVE: begin
                s.solution = fix_assignment(q.assignment);
            end
            default: begin
                s.satisfied = 1'b1;
                for (int p = 0; p < NUM_ROW; p++) begin
                    if (pivot_mask[p] && row_parity(basis_rows[pivot_slot[p]], q.assignment)) begin
                        s.satisfied = 1'b0;
                    end
                end
            end
        endcase
        s.rank       = basis_rank;
        s.consistent = !pivot_mask[0];
        return s;
    endfunction

    function automatic t_req make_req(t_req_kind k, logic [ROW_W-1:0] r, logic [ASG_W-1:0] a);
        t_req q;
        q.req_type   = k;
        q.row_bits   = r;
        q.assignment = a;
        return q;
    endfunction

    // XOR of a few earlier inserted rows: always in the span of the basis
    function automatic logic [ROW_W-1:0] span_row();
        logic [ROW_W-1:0] r;
        int               n;
        r = '0;
        if (inserted_rows.size() != 0) begin
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++) begin
                r ^= inserted_rows[$urandom_range(inserted_rows.size() - 1)];
            end
        end
        return r;
    endfunction

    function automatic t_req random_request();
        t_req             q;
        logic [ROW_W-1:0] w;
        int               pick;
        w = rand_word();
        q.row_bits   = rand_word();
        q.assignment = w[ASG_W-1:0];
        pick = $urandom_range(99);
        if (pick < 12) begin
            q.req_type = REQ_INSERT;
            if ($urandom_range(1) == 1) q.row_bits &= rand_word();
        end else if (pick < 25) begin
            q.req_type = REQ_INSERT;
            q.row_bits = span_row();
            if ($urandom_range(3) == 0) q.row_bits ^= 64'd1 << $urandom_range(63);
        end else if (pick < 40) begin
            q.req_type = REQ_REDUCE;
            q.row_bits = span_row();
        end else if (pick < 55) begin
            q.req_type = REQ_REDUCE;
        end else if (pick < 70) begin
            q.req_type = REQ_SOLVE;
        end else if (pick < 88) begin
            q.req_type   = REQ_EVAL;
            q.assignment = fix_assignment(q.assignment);
        end else begin
            q.req_type = REQ_EVAL;
        end
        return q;
    endfunction

    task automatic report_mismatch(string what, logic [ROW_W-1:0] got, logic [ROW_W-1:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_request(input t_req q);
        while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= q;
        do @(posedge clk); while (o_in_stall);
        if (q.req_type == REQ_INSERT) inserted_rows = {inserted_rows, q.row_bits};
        expected_rsp_q = {expected_rsp_q, predict_response(q)};
    endtask

    task automatic set_traffic(t_traffic mode);
        src_gap_pct    = (mode == TRAFFIC_SRC_GAPS)    ? 69 : (mode == TRAFFIC_BOTH) ? 24 : 0;
        sink_stall_pct = (mode == TRAFFIC_SINK_STALLS) ? 69 : (mode == TRAFFIC_BOTH) ? 24 : 0;
    endtask

    task automatic test_empty_basis();
        send_request(make_req(REQ_REDUCE, '0, '0));
        send_request(make_req(REQ_REDUCE, '1, '1));
        send_request(make_req(REQ_SOLVE,  '1, '1));
        send_request(make_req(REQ_EVAL,   '1, '0));
        send_request(make_req(REQ_EVAL,   '0, '1));
        send_request(make_req(REQ_INSERT, '0, '1));
    endtask

    task automatic test_pivot_updates();
        send_request(make_req(REQ_INSERT, '1, '0));
        send_request(make_req(REQ_INSERT, 64'h8000_0000_0000_0000, '1));
        send_request(make_req(REQ_INSERT, 64'h0000_0000_0000_0021, '0));
        send_request(make_req(REQ_INSERT, 64'h5555_5555_5555_5554, '1));
        send_request(make_req(REQ_REDUCE, '1, '1));
        send_request(make_req(REQ_REDUCE, 64'h8000_0000_0000_0001, '0));
        send_request(make_req(REQ_INSERT, '1, '1));
        send_request(make_req(REQ_SOLVE,  '0, '1));
        send_request(make_req(REQ_SOLVE,  '1, '0));
        send_request(make_req(REQ_EVAL,   '0, fix_assignment('1)));
        send_request(make_req(REQ_EVAL,   '1, '1));
    endtask

    task automatic test_random_traffic(t_traffic mode, int n);
        set_traffic(mode);
        for (int i = 0; i < n; i++) begin
            send_request(random_request());
        end
    endtask

    // fill every missing pivot, constant row last, then work on the full basis
    task automatic test_full_basis();
        logic [ROW_W-1:0] w;
        set_traffic(TRAFFIC_STEADY);
        for (int k = NUM_ROW - 1; k >= 0; k--) begin
            if (!pivot_mask[k]) send_request(make_req(REQ_INSERT, 64'd1 << k, '0));
        end
        w = rand_word();
        send_request(make_req(REQ_INSERT, '1, '1));
        send_request(make_req(REQ_REDUCE, rand_word(), w[ASG_W-1:0]));
        send_request(make_req(REQ_SOLVE,  rand_word(), w[ASG_W-1:0]));
        send_request(make_req(REQ_EVAL,   '0, fix_assignment(w[ASG_W-1:0])));
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    always @(posedge clk) begin
        t_rsp e;
        if (rst_n && out_xfer) begin
            if (expected_rsp_q.size() == 0) begin
                report_mismatch("unexpected result", o_out_data.result_row, '0);
            end else begin
                e = expected_rsp_q.pop_front();
                if (o_out_data.result_row !== e.result_row)
                    report_mismatch("result_row", o_out_data.result_row, e.result_row);
                if (o_out_data.independent !== e.independent)
                    report_mismatch("independent", ROW_W'(o_out_data.independent),
                                    ROW_W'(e.independent));
                if (o_out_data.rank !== e.rank)
                    report_mismatch("rank", ROW_W'(o_out_data.rank), ROW_W'(e.rank));
                if (o_out_data.consistent !== e.consistent)
                    report_mismatch("consistent", ROW_W'(o_out_data.consistent),
                                    ROW_W'(e.consistent));
                if (o_out_data.solution !== e.solution)
                    report_mismatch("solution", ROW_W'(o_out_data.solution),
                                    ROW_W'(e.solution));
                if (o_out_data.satisfied !== e.satisfied)
                    report_mismatch("satisfied", ROW_W'(o_out_data.satisfied),
                                    ROW_W'(e.satisfied));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || in_xfer || out_xfer) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_traffic(TRAFFIC_STEADY);
        test_empty_basis();
        test_pivot_updates();
        test_random_traffic(TRAFFIC_STEADY, 120);
        test_random_traffic(TRAFFIC_SRC_GAPS, 110);
        test_random_traffic(TRAFFIC_SINK_STALLS, 110);
        test_random_traffic(TRAFFIC_BOTH, 110);
        test_full_basis();
        in_valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
sv/gf2rr_pkg.sv
sv/gf2rr_ram.sv
sv/gf2_incremental_row_reduction.sv
verif/tb.sv
